FILE: sv/otfi_pkg.sv
// otfi_pkg: shared types, constants and reset values for the oscillator trim block
// used by otfi_front, otfi_queue, otfi_back and the top level; no dependencies
package otfi_pkg;

  // stamp width default and configuration port sizes
  localparam int STAMP_BITS_DEF = 24;
  localparam int CFG_BITS       = 24;
  localparam int CFG_IDX_BITS   = 3;

  // trim fields
  localparam int FINE_BITS   = 9;
  localparam int COARSE_BITS = 4;
  localparam int TRIM_BITS   = FINE_BITS + COARSE_BITS;
  localparam logic [FINE_BITS-1:0]   FINE_MAX   = 9'h1FF;
  localparam logic [FINE_BITS-1:0]   FINE_MID   = 9'h100;
  localparam logic [COARSE_BITS-1:0] COARSE_MAX = 4'hF;

  // lock counting and coarse escape behavior
  localparam int GOOD_BITS = 2;
  localparam logic [GOOD_BITS-1:0] LOCK_FRAMES = 2'd2;
  localparam bit COARSE_ESCAPE = 1'b1;

  // lock states as seen on cal_state
  localparam logic [1:0] CAL_IDLE   = 2'd0;
  localparam logic [1:0] CAL_ACQ    = 2'd1;
  localparam logic [1:0] CAL_LOCKED = 2'd2;

  // error is clipped to this signed width before the multiply; anything larger
  // saturates the step anyway
  localparam int ERR_BITS   = 27;
  localparam int ERR_LIM    = 2 ** (ERR_BITS - 1) - 1;
  localparam int RECIP_BITS = 17;
  localparam int ROUND_HALF = 32768;
  localparam int Q_SHIFT    = 16;

  localparam int QUEUE_DEPTH = 2;

  // register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_TARGET      = 3'd0,
    REG_WINDOW_LOW  = 3'd1,
    REG_WINDOW_HIGH = 3'd2,
    REG_DEAD_BAND   = 3'd3,
    REG_MAX_STEP    = 3'd4,
    REG_STEP_RECIP  = 3'd5,
    REG_TRIM_NEGATE = 3'd6,
    REG_INIT_TRIM   = 3'd7
  } reg_index_t;

  typedef struct packed {
    logic [23:0]           target_cycles;
    logic [23:0]           window_low;
    logic [23:0]           window_high;
    logic [15:0]           dead_band;
    logic [FINE_BITS-1:0]  max_step;
    logic [RECIP_BITS-1:0] step_recip;
    logic                  trim_negate;
    logic [TRIM_BITS-1:0]  initial_trim;
  } cfg_t;

  // reset values of the registers
  localparam logic [23:0]           RST_TARGET      = 24'd24000;
  localparam logic [23:0]           RST_WINDOW_LOW  = 24'd16000;
  localparam logic [23:0]           RST_WINDOW_HIGH = 24'd36000;
  localparam logic [15:0]           RST_DEAD_BAND   = 16'd16;
  localparam logic [FINE_BITS-1:0]  RST_MAX_STEP    = 9'd64;
  localparam logic [RECIP_BITS-1:0] RST_STEP_RECIP  = 17'd3277;
  localparam logic                  RST_TRIM_NEGATE = 1'b0;
  localparam logic [TRIM_BITS-1:0]  RST_INIT_TRIM   = 13'd4352;

  // event class decided by the front end
  typedef enum logic [1:0] {
    K_ARM  = 2'd0,  // first event, arms only
    K_SKIP = 2'd1,  // interval outside the window
    K_HOLD = 2'd2,  // on target, counts toward lock
    K_CORR = 2'd3   // needs a trim correction
  } kind_t;

  typedef struct packed {
    kind_t                      kind;
    logic signed [ERR_BITS-1:0] err;
  } entry_t;

endpackage

FILE: sv/otfi_front.sv
// otfi_front: takes stamps, forms the interval and classifies each event
// depends on otfi_pkg; feeds otfi_queue
module otfi_front #(
  parameter int STAMP_BITS = otfi_pkg::STAMP_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  otfi_pkg::cfg_t        cfg,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [STAMP_BITS-1:0] stamp,
  output logic                  q_valid,
  input  logic                  q_full,
  output otfi_pkg::entry_t      q_entry
);
  import otfi_pkg::*;

  localparam int W  = (STAMP_BITS > CFG_BITS) ? STAMP_BITS : CFG_BITS;
  localparam int CW = (W + 1 > ERR_BITS + 1) ? W + 1 : ERR_BITS + 1;
  localparam logic signed [CW-1:0] LIM = CW'(ERR_LIM);

  logic [STAMP_BITS-1:0] prev_stamp;
  logic                  armed;
  logic                  a_valid;
  logic                  a_first;
  logic [STAMP_BITS-1:0] a_ivl;
  logic                  accept;
  logic [W-1:0]          ivl_x;
  logic                  in_win;
  logic signed [CW-1:0]  err;
  logic signed [CW-1:0]  db;
  logic                  in_db;
  logic signed [CW-1:0]  err_clip;
  kind_t                 kind;

  // stage holds one word until the queue has room
  assign in_stall = a_valid & q_full;
  assign accept   = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_stamp <= '0;
      armed      <= 1'b0;
      a_valid    <= 1'b0;
    end else begin
      a_valid <= accept | (a_valid & q_full);
      if (accept) begin
        prev_stamp <= stamp;
        armed      <= 1'b1;
      end
    end
  end

  // interval modulo the stamp width
  always_ff @(posedge clk) begin
    if (accept) begin
      a_ivl   <= prev_stamp - stamp;
      a_first <= ~armed;
    end
  end

  // window, dead band and error clipping
  always_comb begin
    ivl_x  = W'(a_ivl);
    in_win = (ivl_x >= W'(cfg.window_low)) && (ivl_x <= W'(cfg.window_high));
    err    = $signed(CW'(a_ivl)) - $signed(CW'(cfg.target_cycles));
    db     = $signed(CW'(cfg.dead_band));
    in_db  = (err >= -db) && (err <= db);
    if (err > LIM) begin
      err_clip = LIM;
    end else if (err < -LIM) begin
      err_clip = -LIM;
    end else begin
      err_clip = err;
    end
    if (a_first) begin
      kind = K_ARM;
    end else if (!in_win) begin
      kind = K_SKIP;
    end else if (in_db) begin
      kind = K_HOLD;
    end else begin
      kind = K_CORR;
    end
  end

  assign q_valid       = a_valid;
  assign q_entry.kind  = kind;
  assign q_entry.err   = err_clip[ERR_BITS-1:0];

endmodule

FILE: sv/otfi_queue.sv
// otfi_queue: short word queue between the classifying front end and the back end
// depends on otfi_pkg
module otfi_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  output logic             full,
  input  otfi_pkg::entry_t wr_entry,
  output logic             rd_valid,
  input  logic             rd_take,
  output otfi_pkg::entry_t rd_entry
);
  import otfi_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

  entry_t          slots [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CNTW-1:0] count;
  logic            push;
  logic            pop;

  assign full     = (count == CNTW'(QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign push     = wr_valid & ~full;
  assign pop      = rd_take & rd_valid;
  assign rd_entry = slots[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // slot storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

endmodule

FILE: sv/otfi_back.sv
// otfi_back: lock counting, scaled correction and trim update, with the output register
// depends on otfi_pkg; reads words from otfi_queue
module otfi_back (
  input  logic                                   clk,
  input  logic                                   rst,
  input  otfi_pkg::cfg_t                         cfg,
  input  logic                                   trim_load,
  input  logic [otfi_pkg::TRIM_BITS-1:0]         trim_init,
  input  logic                                   q_valid,
  output logic                                   q_take,
  input  otfi_pkg::entry_t                       q_entry,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [otfi_pkg::FINE_BITS-1:0]         trim_fine,
  output logic [otfi_pkg::COARSE_BITS-1:0]       trim_coarse,
  output logic [1:0]                             cal_state,
  output logic                                   trim_written,
  output logic                                   frame_accepted
);
  import otfi_pkg::*;

  localparam int PROD_BITS = ERR_BITS + RECIP_BITS + 1;
  localparam int QB        = PROD_BITS - Q_SHIFT;
  localparam int DB        = FINE_BITS + 1;
  localparam int SB        = FINE_BITS + 3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_APPLY
  } state_t;

  state_t                       state;
  kind_t                        e_kind;
  logic signed [ERR_BITS-1:0]   e_err;
  logic signed [PROD_BITS-1:0]  product;
  logic [GOOD_BITS-1:0]         good;
  logic [1:0]                   lock;
  logic [FINE_BITS-1:0]         fine;
  logic [COARSE_BITS-1:0]       coarse;

  logic                         out_free;
  logic signed [PROD_BITS-1:0]  rnd;
  logic signed [QB-1:0]         q;
  logic signed [QB:0]           dneg;
  logic signed [QB:0]           ms;
  logic signed [QB:0]           dcl;
  logic signed [DB-1:0]         dsel;
  logic signed [DB:0]           dext;
  logic signed [DB:0]           dfin;
  logic signed [SB-1:0]         sum;
  logic                         nz;
  logic [GOOD_BITS-1:0]         good_next;
  logic [1:0]                   lock_next;
  logic [FINE_BITS-1:0]         fine_next;
  logic [COARSE_BITS-1:0]       coarse_next;
  logic                         wr_next;
  logic                         acc_next;

  assign q_take   = (state == S_IDLE) && q_valid;
  assign out_free = !out_valid || !out_stall;

  // rounded, negated and clamped step
  always_comb begin
    rnd  = product + PROD_BITS'(ROUND_HALF);
    q    = $signed(rnd[PROD_BITS-1:Q_SHIFT]);
    dneg = -$signed({q[QB-1], q});
    ms   = $signed((QB + 1)'(cfg.max_step));
    if (dneg > ms) begin
      dcl = ms;
    end else if (dneg < -ms) begin
      dcl = -ms;
    end else begin
      dcl = dneg;
    end
    nz   = (dcl != '0);
    dsel = dcl[DB-1:0];
    dext = {dsel[DB-1], dsel};
    dfin = cfg.trim_negate ? -dext : dext;
    sum  = $signed({3'b000, fine}) + $signed({dfin[DB], dfin});
  end

  // next lock and trim state for the word in hand
  always_comb begin
    good_next   = good;
    lock_next   = lock;
    fine_next   = fine;
    coarse_next = coarse;
    wr_next     = 1'b0;
    acc_next    = 1'b0;
    unique case (e_kind) inside
      K_ARM, K_SKIP: begin
      end
      K_HOLD: begin
        acc_next = 1'b1;
        if (lock == CAL_IDLE) begin
          lock_next = CAL_ACQ;
        end
        if (good < LOCK_FRAMES) begin
          good_next = good + 1'b1;
          if (good_next == LOCK_FRAMES) begin
            lock_next = CAL_LOCKED;
          end
        end
      end
      K_CORR: begin
        acc_next  = 1'b1;
        good_next = '0;
        if (lock == CAL_IDLE) begin
          lock_next = CAL_ACQ;
        end
        if (nz) begin
          wr_next = 1'b1;
          if (sum < 0) begin
            if (COARSE_ESCAPE && coarse != '0) begin
              coarse_next = coarse - 1'b1;
              fine_next   = FINE_MID;
            end else begin
              fine_next = '0;
            end
          end else if (sum > $signed(SB'(FINE_MAX))) begin
            if (COARSE_ESCAPE && coarse != COARSE_MAX) begin
              coarse_next = coarse + 1'b1;
              fine_next   = FINE_MID;
            end else begin
              fine_next = FINE_MAX;
            end
          end else begin
            fine_next = sum[FINE_BITS-1:0];
          end
        end
      end
      default: begin
      end
    endcase
  end

  // sequencer: take word, multiply, apply and register the result
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      good      <= '0;
      lock      <= CAL_IDLE;
      fine      <= RST_INIT_TRIM[FINE_BITS-1:0];
      coarse    <= RST_INIT_TRIM[TRIM_BITS-1:FINE_BITS];
    end else begin
      // result word valid: set on apply, cleared once taken
      if (state == S_APPLY && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      // trim: reloaded by a register write, else updated on apply
      if (trim_load) begin
        fine   <= trim_init[FINE_BITS-1:0];
        coarse <= trim_init[TRIM_BITS-1:FINE_BITS];
      end else if (state == S_APPLY && out_free) begin
        fine   <= fine_next;
        coarse <= coarse_next;
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            e_kind <= q_entry.kind;
            e_err  <= q_entry.err;
            state  <= S_MUL;
          end
        end
        S_MUL: begin
          product <= e_err * $signed({1'b0, cfg.step_recip});
          state   <= S_APPLY;
        end
        S_APPLY: begin
          if (out_free) begin
            good           <= good_next;
            lock           <= lock_next;
            trim_fine      <= fine_next;
            trim_coarse    <= coarse_next;
            cal_state      <= lock_next;
            trim_written   <= wr_next;
            frame_accepted <= acc_next;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: sv/oscillator_trim_from_frame_interval_top.sv
// oscillator_trim_from_frame_interval_top: top level, configuration registers and wiring
// depends on otfi_pkg, otfi_front, otfi_queue, otfi_back
//
// Usage: one word per bus frame event arrives on the input channel (stamp,
// in_valid, in_stall) carrying the sampled down-counter value. Each word
// yields exactly one result word on the output channel (trim_fine,
// trim_coarse, cal_state, trim_written, frame_accepted, out_valid,
// out_stall) with the trim and lock state after that event.
// Sustained throughput is set by the back-end sequencer (take, multiply, apply)
// that updates the trim; it takes a new word only after applying the last. The
// front stage and a 2-word queue absorb short bursts, taken one word per cycle
// while in_stall is low. The receiver may hold out_stall as long as it likes:
// the result stays put, the back end waits, and in_stall rises only once the
// queue and the front stage are full. Reset (rst, synchronous) loads all
// register defaults, clears the arm flag and lock state and sets the trim to
// the initial trim. Registers are written through cfg_we/cfg_index/cfg_data
// while idle; the user must ensure this, as the block does not enforce it. A
// write of the initial trim also reloads the fine and coarse trim.
module oscillator_trim_from_frame_interval_top #(
  parameter int STAMP_BITS = otfi_pkg::STAMP_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [otfi_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [otfi_pkg::CFG_BITS-1:0]        cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [STAMP_BITS-1:0]                stamp,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [otfi_pkg::FINE_BITS-1:0]       trim_fine,
  output logic [otfi_pkg::COARSE_BITS-1:0]     trim_coarse,
  output logic [1:0]                           cal_state,
  output logic                                 trim_written,
  output logic                                 frame_accepted
);
  import otfi_pkg::*;

  cfg_t   cfg;
  logic   trim_load;
  logic   fq_valid;
  logic   fq_full;
  entry_t fq_entry;
  logic   bq_valid;
  logic   bq_take;
  entry_t bq_entry;

  assign trim_load = cfg_we && (reg_index_t'(cfg_index) == REG_INIT_TRIM);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_cycles <= RST_TARGET;
      cfg.window_low    <= RST_WINDOW_LOW;
      cfg.window_high   <= RST_WINDOW_HIGH;
      cfg.dead_band     <= RST_DEAD_BAND;
      cfg.max_step      <= RST_MAX_STEP;
      cfg.step_recip    <= RST_STEP_RECIP;
      cfg.trim_negate   <= RST_TRIM_NEGATE;
      cfg.initial_trim  <= RST_INIT_TRIM;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_TARGET:      cfg.target_cycles <= cfg_data[23:0];
        REG_WINDOW_LOW:  cfg.window_low    <= cfg_data[23:0];
        REG_WINDOW_HIGH: cfg.window_high   <= cfg_data[23:0];
        REG_DEAD_BAND:   cfg.dead_band     <= cfg_data[15:0];
        REG_MAX_STEP:    cfg.max_step      <= cfg_data[FINE_BITS-1:0];
        REG_STEP_RECIP:  cfg.step_recip    <= cfg_data[RECIP_BITS-1:0];
        REG_TRIM_NEGATE: cfg.trim_negate   <= cfg_data[0];
        REG_INIT_TRIM:   cfg.initial_trim  <= cfg_data[TRIM_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  otfi_front #(
    .STAMP_BITS(STAMP_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stamp    (stamp),
    .q_valid  (fq_valid),
    .q_full   (fq_full),
    .q_entry  (fq_entry)
  );

  otfi_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (fq_valid),
    .full     (fq_full),
    .wr_entry (fq_entry),
    .rd_valid (bq_valid),
    .rd_take  (bq_take),
    .rd_entry (bq_entry)
  );

  otfi_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .trim_load      (trim_load),
    .trim_init      (cfg_data[TRIM_BITS-1:0]),
    .q_valid        (bq_valid),
    .q_take         (bq_take),
    .q_entry        (bq_entry),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .trim_fine      (trim_fine),
    .trim_coarse    (trim_coarse),
    .cal_state      (cal_state),
    .trim_written   (trim_written),
    .frame_accepted (frame_accepted)
  );

endmodule
